>>> rtl/core/strongly_connected_components_assert.svh
// Assertion macros shared by the checker files of the component search block.
// Depends on nothing; include by bare file name where assertions are written.
`ifndef STRONGLY_CONNECTED_COMPONENTS_ASSERT_SVH
`define STRONGLY_CONNECTED_COMPONENTS_ASSERT_SVH

// Same-cycle implication under reset
`define SCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication under reset
`define SCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/scc_pkg.sv
// Shared codes and controller/datapath interface types of the component search.
// No dependencies.
`timescale 1ns / 1ps

package scc_pkg;

    localparam int FW = 7;

    // Input command codes
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    // Result status codes
    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_FULL   = 2'd1;
    localparam logic [1:0] STS_RANGE  = 2'd2;
    localparam logic [1:0] STS_NO_RUN = 2'd3;

    typedef logic [4:0] t_op;

    // Controller states, also the step code sent to the datapath
    localparam t_op S_IDLE     = 5'd0;
    localparam t_op S_ADD_CHK  = 5'd1;
    localparam t_op S_ADD_WR   = 5'd2;
    localparam t_op S_ADD_LINK = 5'd3;
    localparam t_op S_CLR      = 5'd4;
    localparam t_op S_QRY_CHK  = 5'd5;
    localparam t_op S_QRY_ID   = 5'd6;
    localparam t_op S_QRY_MIN  = 5'd7;
    localparam t_op S_RUN_INIT = 5'd8;
    localparam t_op S_ROOT     = 5'd9;
    localparam t_op S_VISIT    = 5'd10;
    localparam t_op S_HEAD     = 5'd11;
    localparam t_op S_EDGE     = 5'd12;
    localparam t_op S_EDGE_RD  = 5'd13;
    localparam t_op S_V_DISC   = 5'd14;
    localparam t_op S_POP      = 5'd15;
    localparam t_op S_SCC_RD   = 5'd16;
    localparam t_op S_SCC_W    = 5'd17;
    localparam t_op S_SCC_MIN  = 5'd18;
    localparam t_op S_RET      = 5'd19;
    localparam t_op S_RET_RD   = 5'd20;
    localparam t_op S_RET_LD   = 5'd21;
    localparam t_op S_RUN_END  = 5'd22;
    localparam t_op S_FIN      = 5'd23;

    typedef struct packed {
        t_op  op;
        logic take;
    } t_cmd;

    typedef struct packed {
        logic bad_a;
        logic bad_ab;
        logic full;
        logic run_done;
        logic tail_live;
        logic root_over;
        logic root_seen;
        logic edge_live;
        logic v_bad;
        logic v_new;
        logic v_onstk;
        logic stk_full;
        logic scc_root;
        logic scc_more;
        logic fp_one;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/core/scc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, hold when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/scc_ctrl.sv
// Sequencer of the component search: picks the step the datapath performs.
// Depends on scc_pkg.
`timescale 1ns / 1ps

module scc_ctrl import scc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_kind,
    input  t_stat      i_st,
    output logic       o_ready,
    output t_cmd       o_cmd
);

    t_op r_state;
    t_op n_state;
    logic take;

    assign o_ready    = (r_state == S_IDLE);
    assign take       = o_ready && i_valid;
    assign o_cmd.op   = r_state;
    assign o_cmd.take = take;

    // next step
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    unique case (i_kind)
                        CMD_ADD:   n_state = S_ADD_CHK;
                        CMD_RUN:   n_state = S_RUN_INIT;
                        CMD_QUERY: n_state = S_QRY_CHK;
                        CMD_CLEAR: n_state = S_CLR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_CHK:  n_state = (i_st.bad_ab || i_st.full) ? S_FIN : S_ADD_WR;
            S_ADD_WR:   n_state = i_st.tail_live ? S_ADD_LINK : S_FIN;
            S_ADD_LINK: n_state = S_FIN;
            S_CLR:      n_state = S_FIN;
            S_QRY_CHK:  n_state = (i_st.bad_a || !i_st.run_done) ? S_FIN : S_QRY_ID;
            S_QRY_ID:   n_state = S_QRY_MIN;
            S_QRY_MIN:  n_state = S_FIN;
            S_RUN_INIT: n_state = S_ROOT;
            S_ROOT: begin
                if (i_st.root_over) begin
                    n_state = S_RUN_END;
                end else if (!i_st.root_seen) begin
                    n_state = S_VISIT;
                end
            end
            S_VISIT:    n_state = S_HEAD;
            S_HEAD:     n_state = S_EDGE;
            S_EDGE:     n_state = i_st.edge_live ? S_EDGE_RD : S_POP;
            S_EDGE_RD: begin
                if (i_st.v_bad) begin
                    n_state = S_EDGE;
                end else if (i_st.v_new) begin
                    n_state = i_st.stk_full ? S_EDGE : S_VISIT;
                end else if (i_st.v_onstk) begin
                    n_state = S_V_DISC;
                end else begin
                    n_state = S_EDGE;
                end
            end
            S_V_DISC:   n_state = S_EDGE;
            S_POP:      n_state = i_st.scc_root ? S_SCC_RD : S_RET;
            S_SCC_RD:   n_state = S_SCC_W;
            S_SCC_W:    n_state = i_st.scc_more ? S_SCC_RD : S_SCC_MIN;
            S_SCC_MIN:  n_state = S_RET;
            S_RET:      n_state = i_st.fp_one ? S_ROOT : S_RET_RD;
            S_RET_RD:   n_state = S_RET_LD;
            S_RET_LD:   n_state = S_EDGE;
            S_RUN_END:  n_state = S_FIN;
            S_FIN:      n_state = i_st.out_free ? S_IDLE : S_FIN;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/core/scc_dp.sv
// Datapath of the component search: edge lists, search stacks, result tables
// and the output register. Depends on scc_pkg and scc_ram.
`timescale 1ns / 1ps

module scc_dp import scc_pkg::*; #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [13:0] i_in_data,
    input  logic        i_cfg_wr_en,
    input  logic [6:0]  i_cfg_wr_data,
    input  logic        i_out_ready,
    output t_stat       o_st,
    output logic        o_out_valid,
    output logic [23:0] o_out_data,
    output logic [1:0]  o_out_user
);

    localparam int NW  = $clog2(MAX_NODES + 1);
    localparam int EIW = $clog2(MAX_EDGES + 1);
    localparam int SLW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int SW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW  = (NW > FW) ? NW : FW;
    localparam int ND  = MAX_NODES + 1;

    // control and search registers
    logic [NW-1:0]  r_n, r_found, r_clk, r_sp, r_fp, r_u, r_low, r_disc, r_child, r_small;
    logic [NW:0]    r_root;
    logic [EIW-1:0] r_eused, r_fedge, r_link;
    logic [CW-1:0]  r_a, r_b;
    logic           r_done;
    logic [ND-1:0]  r_hval, r_seen, r_onstk;
    logic [1:0]     r_sts;
    logic [NW-1:0]  r_cid, r_cmin;
    logic           r_ovalid;
    logic [23:0]    r_odata;
    logic [1:0]     r_ouser;

    // memory ports
    logic             ht_we, ht_re;
    logic [NW-1:0]    ht_wa, ht_ra;
    logic [2*EIW-1:0] ht_wd, ht_rd;
    logic             tgt_we, tgt_re;
    logic [SLW-1:0]   tgt_wa, tgt_ra;
    logic [NW-1:0]    tgt_wd, tgt_rd;
    logic             nxt_we;
    logic [SLW-1:0]   nxt_wa;
    logic [EIW-1:0]   nxt_wd, nxt_rd;
    logic             disc_we, disc_re;
    logic [NW-1:0]    disc_wa, disc_ra, disc_rd;
    logic             low_we, low_re;
    logic [NW-1:0]    low_rd;
    logic             stk_we, stk_re;
    logic [SW-1:0]    stk_wa, stk_ra;
    logic [NW-1:0]    stk_rd;
    logic             frm_we, frm_re;
    logic [SW-1:0]    frm_wa, frm_ra;
    logic [NW+EIW-1:0] frm_rd;
    logic             cnum_we, cnum_re;
    logic [NW-1:0]    cnum_wa, cnum_ra, cnum_rd;
    logic             csml_we, csml_re;
    logic [NW-1:0]    csml_ra, csml_rd;

    // derived values
    logic [NW-1:0]  a_idx, v, w, nclk, frm_node, cfg_n;
    logic [EIW-1:0] slot1, ht_head, ht_tail;
    logic [CW-1:0]  n_ext, cfg_ext;
    logic           a_ok, b_ok, push, out_free;

    assign a_idx    = r_a[NW-1:0];
    assign n_ext    = CW'(r_n);
    assign a_ok     = (r_a != '0) && (r_a <= n_ext);
    assign b_ok     = (r_b != '0) && (r_b <= n_ext);
    assign ht_head  = ht_rd[2*EIW-1:EIW];
    assign ht_tail  = ht_rd[EIW-1:0];
    assign slot1    = r_eused + EIW'(1);
    assign v        = tgt_rd;
    assign w        = stk_rd;
    assign nclk     = r_clk + NW'(1);
    assign frm_node = frm_rd[NW+EIW-1:EIW];
    assign out_free = !r_ovalid || i_out_ready;
    assign cfg_ext  = CW'(i_cfg_wr_data);
    assign cfg_n    = (cfg_ext == '0) ? NW'(1) :
                      (cfg_ext > CW'(MAX_NODES)) ? NW'(MAX_NODES) : NW'(cfg_ext);

    // status toward the sequencer
    always_comb begin
        o_st.bad_a     = !a_ok;
        o_st.bad_ab    = !a_ok || !b_ok;
        o_st.full      = r_eused >= EIW'(MAX_EDGES);
        o_st.run_done  = r_done;
        o_st.tail_live = r_hval[a_idx] && (ht_tail != '0);
        o_st.root_over = r_root > {1'b0, r_n};
        o_st.root_seen = r_seen[r_root[NW-1:0]];
        o_st.edge_live = r_fedge != '0;
        o_st.v_bad     = (v == '0) || (v > r_n);
        o_st.v_new     = !r_seen[v];
        o_st.v_onstk   = r_onstk[v];
        o_st.stk_full  = (r_sp >= NW'(MAX_NODES)) || (r_fp >= NW'(MAX_NODES));
        o_st.scc_root  = r_low == r_disc;
        o_st.scc_more  = (w != r_u) && (r_sp != '0);
        o_st.fp_one    = r_fp == NW'(1);
        o_st.out_free  = out_free;
    end

    assign push = (i_cmd.op == S_EDGE_RD) && !o_st.v_bad && o_st.v_new && !o_st.stk_full;

    // memory control per step
    always_comb begin
        ht_we = 1'b0; ht_wa = a_idx; ht_wd = '0; ht_re = 1'b0; ht_ra = a_idx;
        tgt_we = 1'b0; tgt_wa = r_eused[SLW-1:0]; tgt_wd = r_b[NW-1:0];
        tgt_re = 1'b0; tgt_ra = '0;
        nxt_we = 1'b0; nxt_wa = r_eused[SLW-1:0]; nxt_wd = '0;
        disc_we = 1'b0; disc_wa = r_u; disc_re = 1'b0; disc_ra = v;
        low_we = 1'b0; low_re = 1'b0;
        stk_we = 1'b0; stk_wa = r_sp[SW-1:0]; stk_re = 1'b0; stk_ra = '0;
        frm_we = 1'b0; frm_wa = '0; frm_re = 1'b0; frm_ra = '0;
        cnum_we = 1'b0; cnum_wa = w; cnum_re = 1'b0; cnum_ra = a_idx;
        csml_we = 1'b0; csml_re = 1'b0; csml_ra = cnum_rd;
        case (i_cmd.op)
            S_ADD_CHK: begin
                ht_re = 1'b1;
            end
            S_ADD_WR: begin
                tgt_we = 1'b1;
                nxt_we = 1'b1;
                ht_we  = 1'b1;
                ht_wd  = o_st.tail_live ? {ht_head, slot1} : {slot1, slot1};
            end
            S_ADD_LINK: begin
                nxt_we = 1'b1;
                nxt_wa = SLW'(r_link - EIW'(1));
                nxt_wd = r_eused;
            end
            S_QRY_CHK: begin
                cnum_re = 1'b1;
            end
            S_QRY_ID: begin
                csml_re = 1'b1;
            end
            S_VISIT: begin
                disc_we = 1'b1;
                stk_we  = 1'b1;
                ht_re   = 1'b1;
                ht_ra   = r_u;
            end
            S_EDGE: begin
                tgt_re = 1'b1;
                tgt_ra = SLW'(r_fedge - EIW'(1));
            end
            S_EDGE_RD: begin
                frm_we  = push;
                frm_wa  = SW'(r_fp - NW'(1));
                low_we  = push;
                disc_re = !o_st.v_bad && !o_st.v_new && o_st.v_onstk;
            end
            S_SCC_RD: begin
                stk_re = 1'b1;
                stk_ra = SW'(r_sp - NW'(1));
            end
            S_SCC_W: begin
                cnum_we = 1'b1;
            end
            S_SCC_MIN: begin
                csml_we = 1'b1;
            end
            S_RET: begin
                frm_re = !o_st.fp_one;
                frm_ra = SW'(r_fp - NW'(2));
            end
            S_RET_RD: begin
                low_re  = 1'b1;
                disc_re = 1'b1;
                disc_ra = frm_node;
            end
            default: begin
            end
        endcase
    end

    // memories
    scc_ram #(.WIDTH(2*EIW), .DEPTH(ND)) u_ht (
        .i_clk(i_clk), .i_we(ht_we), .i_waddr(ht_wa), .i_wdata(ht_wd),
        .i_re(ht_re), .i_raddr(ht_ra), .o_rdata(ht_rd));
    scc_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_tgt (
        .i_clk(i_clk), .i_we(tgt_we), .i_waddr(tgt_wa), .i_wdata(tgt_wd),
        .i_re(tgt_re), .i_raddr(tgt_ra), .o_rdata(tgt_rd));
    scc_ram #(.WIDTH(EIW), .DEPTH(MAX_EDGES)) u_nxt (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_wa), .i_wdata(nxt_wd),
        .i_re(tgt_re), .i_raddr(tgt_ra), .o_rdata(nxt_rd));
    scc_ram #(.WIDTH(NW), .DEPTH(ND)) u_disc (
        .i_clk(i_clk), .i_we(disc_we), .i_waddr(disc_wa), .i_wdata(nclk),
        .i_re(disc_re), .i_raddr(disc_ra), .o_rdata(disc_rd));
    scc_ram #(.WIDTH(NW), .DEPTH(ND)) u_low (
        .i_clk(i_clk), .i_we(low_we), .i_waddr(r_u), .i_wdata(r_low),
        .i_re(low_re), .i_raddr(frm_node), .o_rdata(low_rd));
    scc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_stk (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_wa), .i_wdata(r_u),
        .i_re(stk_re), .i_raddr(stk_ra), .o_rdata(stk_rd));
    scc_ram #(.WIDTH(NW+EIW), .DEPTH(MAX_NODES)) u_frm (
        .i_clk(i_clk), .i_we(frm_we), .i_waddr(frm_wa), .i_wdata({r_u, nxt_rd}),
        .i_re(frm_re), .i_raddr(frm_ra), .o_rdata(frm_rd));
    scc_ram #(.WIDTH(NW), .DEPTH(ND)) u_cnum (
        .i_clk(i_clk), .i_we(cnum_we), .i_waddr(cnum_wa), .i_wdata(r_found),
        .i_re(cnum_re), .i_raddr(cnum_ra), .o_rdata(cnum_rd));
    scc_ram #(.WIDTH(NW), .DEPTH(ND)) u_csml (
        .i_clk(i_clk), .i_we(csml_we), .i_waddr(r_found), .i_wdata(r_small),
        .i_re(csml_re), .i_raddr(csml_ra), .o_rdata(csml_rd));

    // payload registers of the search and query
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_a <= CW'(i_in_data[6:0]);
            r_b <= CW'(i_in_data[13:7]);
        end
        case (i_cmd.op)
            S_ROOT: begin
                r_u <= r_root[NW-1:0];
            end
            S_VISIT: begin
                r_disc <= nclk;
                r_low  <= nclk;
            end
            S_HEAD: begin
                r_fedge <= r_hval[r_u] ? ht_head : '0;
            end
            S_EDGE_RD: begin
                r_fedge <= nxt_rd;
                if (push) begin
                    r_u <= v;
                end
            end
            S_V_DISC: begin
                if (disc_rd < r_low) begin
                    r_low <= disc_rd;
                end
            end
            S_POP: begin
                r_small <= r_u;
            end
            S_SCC_W: begin
                if (w < r_small) begin
                    r_small <= w;
                end
            end
            S_RET: begin
                r_child <= r_low;
            end
            S_RET_RD: begin
                r_u     <= frm_node;
                r_fedge <= frm_rd[EIW-1:0];
            end
            S_RET_LD: begin
                r_low  <= (low_rd < r_child) ? low_rd : r_child;
                r_disc <= disc_rd;
            end
            S_ADD_WR: begin
                r_link <= ht_tail;
            end
            default: begin
            end
        endcase
    end

    // control state: graph size, counters, flags, result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n      <= NW'(1);
            r_eused  <= '0;
            r_found  <= '0;
            r_done   <= 1'b0;
            r_hval   <= '0;
            r_seen   <= '0;
            r_onstk  <= '0;
            r_clk    <= '0;
            r_sp     <= '0;
            r_fp     <= '0;
            r_root   <= '0;
            r_sts    <= STS_OK;
            r_cid    <= '0;
            r_cmin   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_n     <= cfg_n;
                r_done  <= 1'b0;
                r_found <= '0;
            end
            if (i_cmd.take) begin
                r_sts  <= STS_OK;
                r_cid  <= '0;
                r_cmin <= '0;
            end
            case (i_cmd.op)
                S_ADD_CHK: begin
                    if (!a_ok || !b_ok) begin
                        r_sts <= STS_RANGE;
                    end else if (o_st.full) begin
                        r_sts <= STS_FULL;
                    end
                end
                S_ADD_WR: begin
                    r_hval[a_idx] <= 1'b1;
                    r_eused       <= slot1;
                    r_done        <= 1'b0;
                    r_found       <= '0;
                end
                S_CLR: begin
                    r_hval  <= '0;
                    r_eused <= '0;
                    r_done  <= 1'b0;
                    r_found <= '0;
                end
                S_QRY_CHK: begin
                    if (!a_ok) begin
                        r_sts <= STS_RANGE;
                    end else if (!r_done) begin
                        r_sts <= STS_NO_RUN;
                    end
                end
                S_QRY_ID: begin
                    r_cid <= cnum_rd;
                end
                S_QRY_MIN: begin
                    r_cmin <= csml_rd;
                end
                S_RUN_INIT: begin
                    r_seen  <= '0;
                    r_onstk <= '0;
                    r_found <= '0;
                    r_clk   <= '0;
                    r_sp    <= '0;
                    r_fp    <= '0;
                    r_root  <= (NW + 1)'(1);
                end
                S_ROOT: begin
                    if (!o_st.root_over && o_st.root_seen) begin
                        r_root <= r_root + (NW + 1)'(1);
                    end
                end
                S_VISIT: begin
                    r_clk        <= nclk;
                    r_seen[r_u]  <= 1'b1;
                    r_onstk[r_u] <= 1'b1;
                    r_sp         <= r_sp + NW'(1);
                    r_fp         <= r_fp + NW'(1);
                end
                S_POP: begin
                    if (o_st.scc_root) begin
                        r_found <= r_found + NW'(1);
                    end
                end
                S_SCC_RD: begin
                    r_sp <= r_sp - NW'(1);
                end
                S_SCC_W: begin
                    r_onstk[w] <= 1'b0;
                end
                S_RET: begin
                    r_fp <= r_fp - NW'(1);
                    if (o_st.fp_one) begin
                        r_root <= r_root + (NW + 1)'(1);
                    end
                end
                S_RUN_END: begin
                    r_done <= 1'b1;
                end
                default: begin
                end
            endcase
            // output register: load on finish, drop when taken
            if (i_cmd.op == S_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == S_FIN && out_free) begin
            r_odata <= {3'b000, FW'(r_cmin), FW'(r_cid), FW'(r_found)};
            r_ouser <= r_sts;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;
    assign o_out_user  = r_ouser;

endmodule

>>> rtl/core/strongly_connected_components.sv
// Throughput: one word in flight; the next word is taken once the previous
// result sits in the output register. Reset is synchronous, active low: edge
// lists empty, node count 1, no valid run, output empty.
// Top level of the component search; depends on scc_pkg, scc_ctrl, scc_dp.
`timescale 1ns / 1ps

module strongly_connected_components import scc_pkg::*; #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // src_node[6:0], dst_node[13:7]
    input  logic [1:0]  i_s_axis_tuser,  // cmd[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // scc_count[6:0], component_id[13:7],
                                         // component_min[20:14]
    output logic [1:0]  o_m_axis_tuser,  // status[1:0]
    input  logic        i_cfg_wr_en,
    input  logic [6:0]  i_cfg_wr_data
);

    t_cmd  cmd;
    t_stat st;

    scc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_kind  (i_s_axis_tuser),
        .i_st    (st),
        .o_ready (o_s_axis_tready),
        .o_cmd   (cmd)
    );

    scc_dp #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_in_data     (i_s_axis_tdata[13:0]),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_ready   (i_m_axis_tready),
        .o_st          (st),
        .o_out_valid   (o_m_axis_tvalid),
        .o_out_data    (o_m_axis_tdata),
        .o_out_user    (o_m_axis_tuser)
    );

endmodule

>>> rtl/core/scc_checker.sv
// Port-level checks of the component search, bound to the top level.
// Depends on scc_pkg and strongly_connected_components_assert.svh.
`timescale 1ns / 1ps
`include "strongly_connected_components_assert.svh"

module scc_checker import scc_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    // hold a stalled result word
    `SCC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

    // failed commands carry no component
    `SCC_ASSERT_NOW(a_fail_empty, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser != STS_OK), (o_m_axis_tdata[13:7] == 7'd0) && (o_m_axis_tdata[20:14] == 7'd0))

    // a component number never exceeds the count and has a smallest member
    `SCC_ASSERT_NOW(a_comp_bound, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tdata[13:7] != 7'd0), (o_m_axis_tdata[13:7] <= o_m_axis_tdata[6:0]) && (o_m_axis_tdata[20:14] != 7'd0))

endmodule

bind strongly_connected_components scc_checker u_scc_checker (.*);
